// ----- rtl/core/lpg_pkg.sv -----
// Line point generator: shared constants and codes.
// No dependencies; compiled first.
package lpg_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int COLOR_WIDTH     = 16;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

endpackage

// ----- rtl/core/lpg_channels.sv -----
// Line point generator: command and point channel interfaces.
// Depends on lpg_pkg.
interface lpg_in_if #(
    parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
);
    import lpg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [COORD_WIDTH-1:0] end_x;
    logic [COORD_WIDTH-1:0] end_y;
    logic [COLOR_WIDTH-1:0] pixel_color;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y, pixel_color,
        output ready
    );
endinterface

interface lpg_out_if #(
    parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
);
    import lpg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] point_x;
    logic [COORD_WIDTH-1:0] point_y;
    logic [COLOR_WIDTH-1:0] point_color;
    logic                   last_point;

    modport source (
        output valid, point_x, point_y, point_color, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_color, last_point,
        output ready
    );
endinterface

// ----- rtl/core/line_point_generator.sv -----
// Line point generator top level: error-accumulator line rasteriser.
// Depends on lpg_pkg and the channel interfaces in lpg_channels.sv.
// A point beat is registered and offered the cycle after its command beat is taken.
// Throughput: one command beat per cycle while the point register is free or taken.
// A start beat emits the start point; each step emits the current one; span+2 in all.
// Reset (synchronous, active low) clears the line-active flag and the point valid flag.
module line_point_generator #(
    parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpg_in_if.sink    i_line,
    lpg_out_if.source o_point
);
    import lpg_pkg::*;

    localparam int EW = COORD_WIDTH + 1;

    logic                   r_active,    n_active;
    logic [COORD_WIDTH-1:0] r_cur_x,     n_cur_x;
    logic [COORD_WIDTH-1:0] r_cur_y,     n_cur_y;
    logic [EW-1:0]          r_err_x,     n_err_x;
    logic [EW-1:0]          r_err_y,     n_err_y;
    logic [COORD_WIDTH-1:0] r_abs_dx,    n_abs_dx;
    logic [COORD_WIDTH-1:0] r_abs_dy,    n_abs_dy;
    logic [1:0]             r_dir_x,     n_dir_x;
    logic [1:0]             r_dir_y,     n_dir_y;
    logic [COORD_WIDTH-1:0] r_span,      n_span;
    logic [EW-1:0]          r_points_left, n_points_left;
    logic [COLOR_WIDTH-1:0] r_line_color, n_line_color;

    logic                   r_out_valid, n_out_valid;
    logic [COORD_WIDTH-1:0] r_out_x,     n_out_x;
    logic [COORD_WIDTH-1:0] r_out_y,     n_out_y;
    logic [COLOR_WIDTH-1:0] r_out_color, n_out_color;
    logic                   r_out_last,  n_out_last;

    logic          in_ready;
    logic          in_take;
    logic [EW-1:0] sum_x, sum_y;
    logic          adv_x, adv_y;

    function automatic logic [COORD_WIDTH-1:0] move_axis(
        input logic [COORD_WIDTH-1:0] c,
        input logic [1:0]             dir
    );
        logic [COORD_WIDTH-1:0] res;
        case (dir)
            DIR_UP:   res = c + COORD_WIDTH'(1);
            DIR_DOWN: res = c - COORD_WIDTH'(1);
            default:  res = c;
        endcase
        return res;
    endfunction

    assign in_ready     = !r_out_valid || o_point.ready;
    assign in_take      = i_line.valid && in_ready;
    assign i_line.ready = in_ready;

    assign sum_x = r_err_x + {1'b0, r_abs_dx};
    assign sum_y = r_err_y + {1'b0, r_abs_dy};
    assign adv_x = sum_x > {1'b0, r_span};
    assign adv_y = sum_y > {1'b0, r_span};

    always_comb begin
        n_active      = r_active;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_err_x       = r_err_x;
        n_err_y       = r_err_y;
        n_abs_dx      = r_abs_dx;
        n_abs_dy      = r_abs_dy;
        n_dir_x       = r_dir_x;
        n_dir_y       = r_dir_y;
        n_span        = r_span;
        n_points_left = r_points_left;
        n_line_color  = r_line_color;
        n_out_valid   = r_out_valid && !o_point.ready;
        n_out_x       = r_out_x;
        n_out_y       = r_out_y;
        n_out_color   = r_out_color;
        n_out_last    = r_out_last;

        if (in_take && i_line.cmd == CMD_START) begin
            if (i_line.end_x > i_line.start_x) begin
                n_abs_dx = i_line.end_x - i_line.start_x;
                n_dir_x  = DIR_UP;
            end else if (i_line.end_x == i_line.start_x) begin
                n_abs_dx = '0;
                n_dir_x  = DIR_NONE;
            end else begin
                n_abs_dx = i_line.start_x - i_line.end_x;
                n_dir_x  = DIR_DOWN;
            end
            if (i_line.end_y > i_line.start_y) begin
                n_abs_dy = i_line.end_y - i_line.start_y;
                n_dir_y  = DIR_UP;
            end else if (i_line.end_y == i_line.start_y) begin
                n_abs_dy = '0;
                n_dir_y  = DIR_NONE;
            end else begin
                n_abs_dy = i_line.start_y - i_line.end_y;
                n_dir_y  = DIR_DOWN;
            end
            n_span = (n_abs_dx > n_abs_dy) ? n_abs_dx : n_abs_dy;
            // first advance: accumulators start at the axis deltas and never pass span
            n_cur_x       = i_line.start_x;
            n_cur_y       = i_line.start_y;
            n_err_x       = {1'b0, n_abs_dx};
            n_err_y       = {1'b0, n_abs_dy};
            n_line_color  = i_line.pixel_color;
            n_points_left = {1'b0, n_span} + EW'(1);
            n_active      = n_points_left != '0;
            n_out_valid   = 1'b1;
            n_out_x       = i_line.start_x;
            n_out_y       = i_line.start_y;
            n_out_color   = i_line.pixel_color;
            n_out_last    = n_points_left == '0;
        end else if (in_take && r_active) begin
            n_err_x       = adv_x ? sum_x - {1'b0, r_span} : sum_x;
            n_err_y       = adv_y ? sum_y - {1'b0, r_span} : sum_y;
            n_cur_x       = adv_x ? move_axis(r_cur_x, r_dir_x) : r_cur_x;
            n_cur_y       = adv_y ? move_axis(r_cur_y, r_dir_y) : r_cur_y;
            n_points_left = r_points_left - EW'(1);
            n_active      = n_points_left != '0;
            n_out_valid   = 1'b1;
            n_out_x       = r_cur_x;
            n_out_y       = r_cur_y;
            n_out_color   = r_line_color;
            n_out_last    = n_points_left == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x       <= n_cur_x;
        r_cur_y       <= n_cur_y;
        r_err_x       <= n_err_x;
        r_err_y       <= n_err_y;
        r_abs_dx      <= n_abs_dx;
        r_abs_dy      <= n_abs_dy;
        r_dir_x       <= n_dir_x;
        r_dir_y       <= n_dir_y;
        r_span        <= n_span;
        r_points_left <= n_points_left;
        r_line_color  <= n_line_color;
        r_out_x       <= n_out_x;
        r_out_y       <= n_out_y;
        r_out_color   <= n_out_color;
        r_out_last    <= n_out_last;
    end

    assign o_point.valid       = r_out_valid;
    assign o_point.point_x     = r_out_x;
    assign o_point.point_y     = r_out_y;
    assign o_point.point_color = r_out_color;
    assign o_point.last_point  = r_out_last;

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_line.cmd == CMD_START) |=> (r_out_valid && r_active && !r_out_last))
        else $error("start beat did not open a line");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_active)
        else $error("line still active after last point");

    a_err_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_err_x <= {1'b0, r_span}))
        else $error("x accumulator beyond span");

    a_err_y_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_err_y <= {1'b0, r_span}))
        else $error("y accumulator beyond span");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_line.cmd == CMD_STEP && !r_active) |=> !r_out_valid)
        else $error("step beat while idle produced a point");

endmodule
